// File: hdl/ipv4_header_inserter_assert.svh
// assertion macros for the ipv4 header inserter
`ifndef IPV4_HEADER_INSERTER_ASSERT_SVH
`define IPV4_HEADER_INSERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define IPV4HI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipv4_header_inserter: implication check failed");

`define IPV4HI_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ipv4_header_inserter: invariant check failed");

`else

`define IPV4HI_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define IPV4HI_ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

// File: hdl/ipv4hi_pkg.sv
// shared types and constants for the ipv4 header inserter
package ipv4hi_pkg;

  localparam int HDR_BYTES = 20;
  localparam int HDR_IDX_W = 5;

  localparam logic [7:0]  VER_IHL     = 8'h45;
  localparam logic [15:0] FLAGS_DF    = 16'h4000;
  localparam logic [7:0]  TTL_DEFAULT = 8'd64;
  localparam logic [15:0] HDR_LEN     = 16'd20;

  localparam logic [1:0] CFG_SRC_IP      = 2'd0;
  localparam logic [1:0] CFG_SUBNET_MASK = 2'd1;
  localparam logic [1:0] CFG_GATEWAY_MAC = 2'd2;

  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] dest_ip;
    logic [15:0] payload_len;
  } hdr_fields_t;

endpackage

// File: hdl/ipv4hi_hdr.sv
// ipv4 header byte generator with header checksum
module ipv4hi_hdr (
  input  logic [31:0]              src_ip,
  input  ipv4hi_pkg::hdr_fields_t  fields,
  input  ipv4hi_pkg::hdr_idx_t     idx,
  output logic [7:0]               hdr_byte
);
  import ipv4hi_pkg::*;

  logic [15:0] total_len;
  logic [19:0] sum_raw;
  logic [16:0] sum_fold1;
  logic [15:0] sum_fold2;
  logic [15:0] checksum;
  logic [7:0]  hdr [HDR_BYTES];

  assign total_len = fields.payload_len + HDR_LEN;

  assign sum_raw = 20'({VER_IHL, 8'h00}) + 20'(total_len) + 20'(FLAGS_DF)
                 + 20'({TTL_DEFAULT, fields.protocol})
                 + 20'(src_ip[31:16]) + 20'(src_ip[15:0])
                 + 20'(fields.dest_ip[31:16]) + 20'(fields.dest_ip[15:0]);

  assign sum_fold1 = 17'(sum_raw[15:0]) + 17'(sum_raw[19:16]);
  assign sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);
  assign checksum  = ~sum_fold2;

  always_comb begin
    hdr[0]  = VER_IHL;
    hdr[1]  = 8'h00;
    hdr[2]  = total_len[15:8];
    hdr[3]  = total_len[7:0];
    hdr[4]  = 8'h00;
    hdr[5]  = 8'h00;
    hdr[6]  = FLAGS_DF[15:8];
    hdr[7]  = FLAGS_DF[7:0];
    hdr[8]  = TTL_DEFAULT;
    hdr[9]  = fields.protocol;
    hdr[10] = checksum[15:8];
    hdr[11] = checksum[7:0];
    hdr[12] = src_ip[31:24];
    hdr[13] = src_ip[23:16];
    hdr[14] = src_ip[15:8];
    hdr[15] = src_ip[7:0];
    hdr[16] = fields.dest_ip[31:24];
    hdr[17] = fields.dest_ip[23:16];
    hdr[18] = fields.dest_ip[15:8];
    hdr[19] = fields.dest_ip[7:0];
  end

  always_comb begin
    if (idx < hdr_idx_t'(HDR_BYTES)) begin
      hdr_byte = hdr[idx];
    end else begin
      hdr_byte = 8'h00;
    end
  end

endmodule

// File: hdl/ipv4_header_inserter.sv
// ipv4 header inserter top level
// Payload bytes enter on the s_axis side and leave on the m_axis side, with
// one input register and one output register between them. Bytes that follow
// the first one of a packet pass at one per cycle unless m_axis_tready stalls
// the output. The first byte of an off-subnet packet is sent behind its header:
// the single output register sends the 20 header bytes and then the byte itself
// one per cycle, again unless stalled; the next byte is taken in the cycle its
// predecessor finishes. A same-subnet first byte gives a single error transfer,
// and dropped or stray bytes are absorbed at one per cycle.
module ipv4_header_inserter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0], protocol[15:8], dest_ip[47:16], payload_len[63:48]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // first_byte
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], next hop mac[55:8]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // error
  output logic        m_axis_tuser
);
  import ipv4hi_pkg::*;

`include "ipv4_header_inserter_assert.svh"

  logic [31:0] src_ip;
  logic [31:0] subnet_mask;
  logic [47:0] gateway_mac;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_first;
  logic        in_last;
  hdr_fields_t in_fields;

  hdr_idx_t    hdr_idx;
  logic        in_packet;
  logic        dropping;

  logic [7:0]  out_byte;
  logic [47:0] hop_mac;
  logic        out_error;
  logic        out_eor;

  logic        out_load;
  logic        subnet_match;
  logic        emit;
  logic        final_step;
  logic        consume;
  logic [7:0]  hdr_byte;

  ipv4hi_hdr u_hdr (
    .src_ip   (src_ip),
    .fields   (in_fields),
    .idx      (hdr_idx),
    .hdr_byte (hdr_byte)
  );

  assign cfg_ready = 1'b1;

  assign out_load     = !m_axis_tvalid || m_axis_tready;
  assign subnet_match = ((in_fields.dest_ip ^ src_ip) & subnet_mask) == 32'd0;
  assign emit         = in_first || (in_packet && !dropping);
  assign final_step   = !in_first || subnet_match || (hdr_idx == hdr_idx_t'(HDR_BYTES));
  assign consume      = in_valid && (!emit || (out_load && final_step));
  assign s_axis_tready = !in_valid || consume;

  assign m_axis_tdata = {hop_mac, out_byte};
  assign m_axis_tlast = out_eor;
  assign m_axis_tuser = out_error;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_ip      <= '0;
      subnet_mask <= '0;
      gateway_mac <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SRC_IP:      src_ip      <= cfg_data[31:0];
        CFG_SUBNET_MASK: subnet_mask <= cfg_data[31:0];
        CFG_GATEWAY_MAC: gateway_mac <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte               <= s_axis_tdata[7:0];
      in_fields.protocol    <= s_axis_tdata[15:8];
      in_fields.dest_ip     <= s_axis_tdata[47:16];
      in_fields.payload_len <= s_axis_tdata[63:48];
      in_first              <= s_axis_tuser;
      in_last               <= s_axis_tlast;
    end
  end

  // packet state and header position
  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet <= 1'b0;
      dropping  <= 1'b0;
      hdr_idx   <= '0;
    end else begin
      if (in_valid && emit && out_load && in_first && !subnet_match) begin
        if (hdr_idx == hdr_idx_t'(HDR_BYTES)) begin
          hdr_idx <= '0;
        end else begin
          hdr_idx <= hdr_idx + hdr_idx_t'(1);
        end
      end
      if (consume) begin
        if (in_first) begin
          in_packet <= !in_last;
          dropping  <= subnet_match && !in_last;
        end else if (in_last) begin
          in_packet <= 1'b0;
          dropping  <= 1'b0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= in_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid && emit) begin
      if (in_first && subnet_match) begin
        out_byte  <= 8'h00;
        hop_mac   <= '0;
        out_error <= 1'b1;
        out_eor   <= 1'b1;
      end else if (in_first && (hdr_idx != hdr_idx_t'(HDR_BYTES))) begin
        out_byte  <= hdr_byte;
        hop_mac   <= gateway_mac;
        out_error <= 1'b0;
        out_eor   <= 1'b0;
      end else begin
        out_byte  <= in_byte;
        hop_mac   <= gateway_mac;
        out_error <= 1'b0;
        out_eor   <= in_last;
      end
    end
  end

  `IPV4HI_ASSERT_IMPLIES(a_hdr_idx_needs_first, clk, rst, hdr_idx != '0, in_valid && in_first)
  `IPV4HI_ASSERT_ALWAYS(a_hdr_idx_range, clk, rst, hdr_idx <= hdr_idx_t'(HDR_BYTES))
  `IPV4HI_ASSERT_IMPLIES(a_drop_in_packet, clk, rst, dropping, in_packet)
  `IPV4HI_ASSERT_IMPLIES(a_error_shape, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0))

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the ipv4 header inserter with its own header and checksum predictor
module tb_top;
  import ipv4hi_pkg::*;

  localparam int LIMIT_NS = 3_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [7:0]  out_byte;
    logic [47:0] hop_mac;
    logic        error;
    logic        end_of_run;
  } wire_byte_t;

  typedef enum {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_e;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // predictor copy of registers and packet state
  logic [31:0] own_ip;
  logic [31:0] own_mask;
  logic [47:0] next_hop_mac;
  logic        pkt_open;
  logic        pkt_dropping;

  wire_byte_t  wire_bytes_q[$];

  int          fail_count = 0;
  int          items_in = 0;
  int          results_out = 0;
  int          headers_built = 0;
  int          subnet_errors = 0;
  int          settings_used = 0;

  logic        tx_bursty;
  logic        tx_active;
  int          burst_left;
  rx_mode_e    rx_mode;
  logic [15:0] rx_shape;
  int unsigned rx_cycle = 0;

  ipv4_header_inserter uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_mode)
      RX_ALWAYS: begin
        m_axis_tready <= 1'b1;
      end
      RX_PATTERN: begin
        m_axis_tready <= rx_shape[rx_cycle % 16];
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  always @(posedge clk) begin
    wire_byte_t exp_wb;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (wire_bytes_q.size() == 0) begin
        $error("unexpected output transfer: out_byte %h error %b", m_axis_tdata[7:0],
               m_axis_tuser);
        fail_count++;
      end else begin
        exp_wb = wire_bytes_q.pop_front();
        results_out++;
        if (m_axis_tdata[7:0] !== exp_wb.out_byte) begin
          $error("out_byte: expected %h, actual %h", exp_wb.out_byte, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[55:8] !== exp_wb.hop_mac) begin
          $error("hop_mac: expected %h, actual %h", exp_wb.hop_mac, m_axis_tdata[55:8]);
          fail_count++;
        end
        if (m_axis_tuser !== exp_wb.error) begin
          $error("error: expected %b, actual %b", exp_wb.error, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tlast !== exp_wb.end_of_run) begin
          $error("end_of_run: expected %b, actual %b", exp_wb.end_of_run, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  task automatic predict_wire_bytes(input logic [7:0] data, input logic first, input logic last,
                                    input logic [7:0] proto, input logic [31:0] dst,
                                    input logic [15:0] plen);
    logic [7:0]  hdr [HDR_BYTES];
    logic [15:0] tot;
    logic [31:0] sum;
    if (first) begin
      if ((dst & own_mask) == (own_ip & own_mask)) begin
        wire_bytes_q.push_back('{8'h00, 48'h0, 1'b1, 1'b1});
        pkt_open = !last;
        pkt_dropping = !last;
        subnet_errors++;
      end else begin
        tot = plen + HDR_LEN;
        hdr[0] = VER_IHL;
        hdr[1] = 8'h00;
        hdr[2] = tot[15:8];
        hdr[3] = tot[7:0];
        hdr[4] = 8'h00;
        hdr[5] = 8'h00;
        hdr[6] = FLAGS_DF[15:8];
        hdr[7] = FLAGS_DF[7:0];
        hdr[8] = TTL_DEFAULT;
        hdr[9] = proto;
        hdr[10] = 8'h00;
        hdr[11] = 8'h00;
        for (int i = 0; i < 4; i++) begin
          hdr[12 + i] = own_ip[31 - 8 * i -: 8];
          hdr[16 + i] = dst[31 - 8 * i -: 8];
        end
        // ones' complement sum with end-around carry
        sum = 32'h0;
        for (int i = 0; i < HDR_BYTES; i += 2) begin
          sum = sum + {16'h0, hdr[i], hdr[i + 1]};
          if (sum > 32'h0000_FFFF) sum = {16'h0, sum[15:0]} + (sum >> 16);
        end
        sum = ~sum;
        hdr[10] = sum[15:8];
        hdr[11] = sum[7:0];
        for (int i = 0; i < HDR_BYTES; i++) wire_bytes_q.push_back('{hdr[i], next_hop_mac, 1'b0, 1'b0});
        wire_bytes_q.push_back('{data, next_hop_mac, 1'b0, last});
        pkt_open = !last;
        pkt_dropping = 1'b0;
        headers_built++;
      end
    end else if (pkt_open) begin
      if (pkt_dropping) begin
        if (last) begin
          pkt_open = 1'b0;
          pkt_dropping = 1'b0;
        end
      end else begin
        wire_bytes_q.push_back('{data, next_hop_mac, 1'b0, last});
        if (last) pkt_open = 1'b0;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] data, input logic first, input logic last,
                           input logic [7:0] proto, input logic [31:0] dst,
                           input logic [15:0] plen);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {plen, dst, proto, data};
    s_axis_tlast <= last;
    s_axis_tuser <= first;
    tx_active = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_wire_bytes(data, first, last, proto, dst, plen);
    items_in++;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        s_axis_tvalid <= 1'b0;
        tx_active = 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    if (tx_active) begin
      s_axis_tvalid <= 1'b0;
      tx_active = 1'b0;
    end
    while (wire_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SRC_IP: begin
        own_ip = value[31:0];
      end
      CFG_SUBNET_MASK: begin
        own_mask = value[31:0];
      end
      CFG_GATEWAY_MAC: begin
        next_hop_mac = value;
      end
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] ip, input logic [31:0] mask,
                               input logic [47:0] mac);
    wait_drained();
    write_reg(CFG_SRC_IP, {16'($urandom), ip});
    write_reg(CFG_SUBNET_MASK, {16'($urandom), mask});
    write_reg(CFG_GATEWAY_MAC, mac);
    settings_used++;
  endtask

  function automatic logic [31:0] pick_dest(input logic on_subnet);
    logic [31:0] d;
    d = $urandom;
    if (on_subnet) return (own_ip & own_mask) | (d & ~own_mask);
    for (int i = 0; i < 16 && ((d & own_mask) == (own_ip & own_mask)); i++) d = $urandom;
    return d;
  endfunction

  task automatic test_reset_registers();
    // all registers zero: every destination is local
    send_byte(8'hA5, 1'b1, 1'b1, 8'h11, 32'h0A00_0001, 16'd100);
    send_byte(8'h5A, 1'b1, 1'b0, 8'h06, 32'hFFFF_FFFF, 16'd3);
    send_byte(8'h00, 1'b0, 1'b0, 8'h00, 32'h0, 16'd0);
    send_byte(8'hFF, 1'b0, 1'b1, 8'hFF, 32'h0, 16'd0);
    send_byte(8'h3C, 1'b0, 1'b1, 8'h06, 32'h0, 16'd0);
    wait_drained();
  endtask

  task automatic test_register_writes();
    write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_SRC_IP, {16'hFFFF, 32'hC0A8_0A05});
    write_reg(CFG_SUBNET_MASK, {16'h5A5A, 32'hFFFF_FF00});
    write_reg(CFG_GATEWAY_MAC, 48'hFFFF_FFFF_FFFF);
    settings_used++;
  endtask

  task automatic test_header_fields();
    send_byte(8'hFF, 1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'd1);
    send_byte(8'h00, 1'b1, 1'b0, 8'h00, 32'h0000_0000, 16'd65515);
    send_byte(8'h5A, 1'b0, 1'b0, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_byte(8'hA5, 1'b0, 1'b1, 8'h00, 32'h0, 16'h0);
    // zero length and wrap of total length
    send_byte(8'h12, 1'b1, 1'b1, 8'h06, 32'h0808_0808, 16'd0);
    send_byte(8'h34, 1'b1, 1'b1, 8'h11, 32'h0808_0404, 16'd65535);
    send_byte(8'h56, 1'b1, 1'b1, 8'h01, 32'hC0A8_0B05, 16'd65516);
    wait_drained();
  endtask

  task automatic test_special_cases();
    // local destination on a one-byte packet
    send_byte(8'h77, 1'b1, 1'b1, 8'h06, 32'hC0A8_0A63, 16'd40);
    // local destination, rest of packet dropped
    send_byte(8'h88, 1'b1, 1'b0, 8'h06, 32'hC0A8_0AFE, 16'd40);
    send_byte(8'h99, 1'b0, 1'b0, 8'h06, 32'h0808_0808, 16'd40);
    send_byte(8'hAA, 1'b0, 1'b1, 8'h06, 32'h0808_0808, 16'd40);
    // new first byte while dropping
    send_byte(8'hBB, 1'b1, 1'b0, 8'h06, 32'hC0A8_0A01, 16'd8);
    send_byte(8'hCC, 1'b1, 1'b1, 8'h11, 32'h0A0A_0A0A, 16'd8);
    // new first byte abandons an open packet
    send_byte(8'hDD, 1'b1, 1'b0, 8'h06, 32'hAC10_0001, 16'd3);
    send_byte(8'hEE, 1'b0, 1'b0, 8'h06, 32'h0, 16'd3);
    send_byte(8'hF0, 1'b1, 1'b1, 8'h06, 32'hAC10_0002, 16'd1);
    // stray bytes while idle
    send_byte(8'hF1, 1'b0, 1'b0, 8'h06, 32'h0808_0808, 16'd1);
    send_byte(8'hF2, 1'b0, 1'b1, 8'h06, 32'h0808_0808, 16'd1);
    // fewer bytes than payload_len says
    send_byte(8'hF3, 1'b1, 1'b0, 8'h06, 32'h0808_0808, 16'd500);
    send_byte(8'hF4, 1'b0, 1'b1, 8'h06, 32'h0, 16'd0);
    wait_drained();
  endtask

  task automatic run_random_traffic(input int target);
    int          sent;
    int          len;
    int          kind;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] plen;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      proto = 8'($urandom);
      plen = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(1, 65515));
      len = $urandom_range(1, 6);
      if (kind < 80) begin
        dst = pick_dest(kind >= 65);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom), i == 0, i == len - 1, (i == 0) ? proto : 8'($urandom),
                    (i == 0) ? dst : $urandom, (i == 0) ? plen : 16'($urandom));
          sent++;
        end
      end else if (kind < 90) begin
        // broken packet with no last byte
        dst = pick_dest(1'b0);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom), i == 0, 1'b0, proto, dst, plen);
          sent++;
        end
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom), $urandom, 16'($urandom));
        sent++;
      end
    end
    // close any open packet before the next register write
    send_byte(8'($urandom), 1'b1, 1'b1, 8'($urandom), pick_dest(1'b0),
              16'($urandom_range(1, 1500)));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    tx_bursty = 1'b1;
    rx_mode = RX_RANDOM;
    apply_setting($urandom, 32'hFFFF_FF00, {16'($urandom), 32'($urandom)});
    run_random_traffic(30);

    tx_bursty = 1'b0;
    rx_mode = RX_ALWAYS;
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0);
    run_random_traffic(20);

    tx_bursty = 1'b1;
    rx_mode = RX_PATTERN;
    rx_shape = 16'h0101;
    apply_setting(32'h0000_0000, 32'h0000_0000, 48'h0123_4567_89AB);
    run_random_traffic(10);

    tx_bursty = 1'b1;
    rx_mode = RX_PATTERN;
    rx_shape = 16'b1011_0110_1110_0101;
    apply_setting(32'h0000_0000, 32'hFFFF_FFFF << $urandom_range(1, 31),
                  {16'($urandom), 32'($urandom)});
    run_random_traffic(30);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SRC_IP;
    cfg_data <= 48'h0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 64'h0;
    s_axis_tlast <= 1'b0;
    s_axis_tuser <= 1'b0;
    m_axis_tready <= 1'b0;
    own_ip = 32'h0;
    own_mask = 32'h0;
    next_hop_mac = 48'h0;
    pkt_open = 1'b0;
    pkt_dropping = 1'b0;
    tx_bursty = 1'b1;
    tx_active = 1'b0;
    burst_left = 3;
    rx_mode = RX_PATTERN;
    rx_shape = 16'b1110_1101_0011_1011;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_registers();
    test_register_writes();
    test_header_fields();
    test_special_cases();
    test_random_traffic();
    wait_drained();

    $display("covered %0d input transfers and %0d checked output transfers over %0d settings",
             items_in, results_out, settings_used);
    $display("headers built: %0d, local-subnet errors: %0d", headers_built, subnet_errors);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d output transfers still expected", wire_bytes_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
